### hdl/uer_pkg.sv
`default_nettype none

package uer_pkg;

    // One counter tick as delivered on the input channel.
    typedef struct packed {
        logic start_req;
        logic echo;
    } in_item_t;

    // One result per tick.
    typedef struct packed {
        logic        trigger;
        logic        busy_res;
        logic        done_res;
        logic        no_echo;
        logic [15:0] echo_us;
        logic [15:0] distance_cm;
    } out_item_t;

    // Configuration register indexes.
    localparam logic [7:0] CFG_COUNTER_FREQ_KHZ = 8'd0;
    localparam logic [7:0] CFG_TRIGGER_TICKS    = 8'd1;
    localparam logic [7:0] CFG_TIMEOUT_TICKS    = 8'd2;
    localparam logic [7:0] CFG_TEMPERATURE_C    = 8'd3;

    // Tick counter operations.
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_SET1,
        CNT_INC
    } cnt_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        cnt_op_t cnt_op;
        logic    push;
        logic    push_calc;
        logic    res_trig;
        logic    res_busy;
        logic    res_done;
        logic    res_err;
        logic    prod_cap;
        logic    prod_us;
        logic    div_start;
        logic    div_sel_air;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start;
        logic echo;
        logic echo_rise;
        logic tlen_le1;
        logic inc_ge_tlen;
        logic inc_ge_lim;
        logic full1;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/ultrasonic_echo_ranger_core.sv
// Each accepted tick pushes its result into the two-slot result buffer, except the tick that
// ends a pulse, whose result is pushed after two 16-step divisions, or after only the second
// one when the microsecond value saturates and the first division is skipped.
// Throughput: one tick per cycle while the buffer's second slot is free; the ending tick
// blocks input while the shared divider runs. The two-slot result buffer takes one more tick.
// Reset (rst_n, asynchronous, active low) returns to idle and loads the default registers.
`default_nettype none

module ultrasonic_echo_ranger_core
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    uer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    uer_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

### hdl/uer_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, 16-bit quotient.
// A quotient that would not fit in 16 bits saturates to all ones.
module uer_div
    import uer_pkg::*;
#(
    parameter int DW = 26
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [15:0]   divisor,
    output logic               done,
    output logic [15:0]        quot
);

    localparam int SW = (DW > 32) ? DW : 32;

    logic          run_reg;
    logic          done_reg;
    logic          sat_reg;
    logic [3:0]    cnt_reg;
    logic [15:0]   rem_reg;
    logic [15:0]   low_reg;
    logic [15:0]   div_reg;

    logic          sat;
    logic [DW-1:0] hi_part;
    logic [16:0]   trial;
    logic          bit_q;
    logic [15:0]   rem_next;

    // Saturation check: the quotient fits only if dividend < divisor * 2^16.
    assign sat     = SW'(dividend) >= SW'({divisor, 16'h0000});
    assign hi_part = dividend >> 16;

    // One restoring step.
    assign trial    = {rem_reg, low_reg[15]};
    assign bit_q    = trial >= {1'b0, div_reg};
    assign rem_next = bit_q ? 16'(trial - {1'b0, div_reg}) : trial[15:0];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (sat)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= sat;
            div_reg <= divisor;
            rem_reg <= hi_part[15:0];
            low_reg <= dividend[15:0];
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[14:0], bit_q};
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? 16'hFFFF : low_reg;

endmodule

`default_nettype wire

### hdl/uer_dp.sv
`default_nettype none

// Datapath: configuration registers, tick counter, edge detect,
// microsecond and centimeter arithmetic, and the two-slot result buffer.
module uer_dp
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      stat
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int DW = CW + 10;

    localparam logic [DW-1:0] US_PER_MS     = DW'(1000);
    localparam logic [DW-1:0] CM_SCALE      = DW'(100);
    localparam logic [12:0]   AIR_BASE      = 13'd3313;
    localparam logic [12:0]   AIR_PER_DEG   = 13'd6;
    localparam logic [12:0]   DIV100_RECIP  = 13'd5243;
    localparam int            DIV100_SHIFT  = 19;
    localparam logic [9:0]    AIR_DROP      = 10'd15;
    localparam logic [CW-1:0] COUNT_MAX     = CW'({COUNT_BITS{1'b1}});

    logic [15:0]   freq_reg;
    logic [15:0]   trig_ticks_reg;
    logic [15:0]   timeout_reg;
    logic [7:0]    temp_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          echo_prev_reg;

    logic [12:0]   air_a_reg;
    logic [6:0]    air_q_reg;
    logic [12:0]   air_reg;
    logic [25:0]   air_prod;

    logic [DW-1:0] prod_reg;
    logic [15:0]   us_reg;

    logic          valid0_reg;
    logic          full1_reg;
    out_item_t     out0_reg;
    out_item_t     out1_reg;
    out_item_t     push_item;
    logic          pop;

    logic [CW:0]   inc;
    logic [CW-1:0] timeout_ext;
    logic [CW-1:0] lim_sat;
    logic [CW-1:0] lim;
    logic [15:0]   tlen;
    logic [15:0]   divisor;
    logic          div_done;
    logic [15:0]   quot;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg       <= 16'd1000;
            trig_ticks_reg <= 16'd10;
            timeout_reg    <= 16'd65535;
            temp_reg       <= 8'd22;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COUNTER_FREQ_KHZ: freq_reg       <= cfg_data;
                CFG_TRIGGER_TICKS:    trig_ticks_reg <= cfg_data;
                CFG_TIMEOUT_TICKS:    timeout_reg    <= cfg_data;
                CFG_TEMPERATURE_C:    temp_reg       <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Limits: the timeout is capped at the counter maximum, zero acts as one.
    assign timeout_ext = CW'(timeout_reg);
    assign lim_sat     = (timeout_ext > COUNT_MAX) ? COUNT_MAX : timeout_ext;
    assign lim         = (lim_sat == '0) ? CW'(1) : lim_sat;
    assign tlen        = (trig_ticks_reg == 16'd0) ? 16'd1 : trig_ticks_reg;
    assign inc         = {1'b0, count_reg} + (CW+1)'(1);

    // Tick counter.
    always_comb
    begin
        case (cmd.cnt_op)
            CNT_CLR:  count_next = '0;
            CNT_SET1: count_next = CW'(1);
            CNT_INC:  count_next = inc[CW-1:0];
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            echo_prev_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.accept)
            begin
                echo_prev_reg <= in_data.echo;
            end
        end
    end

    // Speed of sound in dm/s, settled through air_a_reg, air_q_reg and air_reg after a temperature write.
    // The hundreds digit comes from a reciprocal multiply that is exact here.
    assign air_prod = air_a_reg * DIV100_RECIP;

    always_ff @(posedge clk)
    begin
        air_a_reg <= AIR_BASE + AIR_PER_DEG * 13'(temp_reg);
        air_q_reg <= air_prod[DIV100_SHIFT +: 7];
        air_reg   <= air_a_reg - 13'(10'(air_q_reg) * AIR_DROP);
    end

    // Product register feeding the divider.
    always_ff @(posedge clk)
    begin
        if (cmd.prod_cap)
        begin
            prod_reg <= DW'(count_reg) * US_PER_MS;
        end
        else if (cmd.prod_us)
        begin
            prod_reg <= DW'(quot) * CM_SCALE;
            us_reg   <= quot;
        end
    end

    assign divisor = cmd.div_sel_air ? {3'b000, air_reg} : freq_reg;

    uer_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quot     (quot)
    );

    // Result item to be queued.
    always_comb
    begin
        if (cmd.push_calc)
        begin
            push_item.trigger     = 1'b0;
            push_item.busy_res    = 1'b0;
            push_item.done_res    = 1'b1;
            push_item.no_echo     = 1'b0;
            push_item.echo_us     = us_reg;
            push_item.distance_cm = {1'b0, quot[15:1]};
        end
        else
        begin
            push_item.trigger     = cmd.res_trig;
            push_item.busy_res    = cmd.res_busy;
            push_item.done_res    = cmd.res_done;
            push_item.no_echo     = cmd.res_err;
            push_item.echo_us     = 16'd0;
            push_item.distance_cm = 16'd0;
        end
    end

    // Two-slot result buffer; a push never meets a full second slot.
    assign pop = valid0_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            full1_reg  <= 1'b0;
        end
        else
        begin
            if (pop && full1_reg)
            begin
                full1_reg <= 1'b0;
            end
            else if (pop && !cmd.push)
            begin
                valid0_reg <= 1'b0;
            end
            else if (!pop && cmd.push)
            begin
                if (!valid0_reg)
                begin
                    valid0_reg <= 1'b1;
                end
                else
                begin
                    full1_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && full1_reg)
        begin
            out0_reg <= out1_reg;
        end
        else if (cmd.push && (pop || !valid0_reg))
        begin
            out0_reg <= push_item;
        end
        else if (cmd.push)
        begin
            out1_reg <= push_item;
        end
    end

    assign out_valid = valid0_reg;
    assign out_data  = out0_reg;

    // Status toward the controller.
    assign stat.start       = in_data.start_req;
    assign stat.echo        = in_data.echo;
    assign stat.echo_rise   = in_data.echo && !echo_prev_reg;
    assign stat.tlen_le1    = tlen == 16'd1;
    assign stat.inc_ge_tlen = inc >= (CW+1)'(tlen);
    assign stat.inc_ge_lim  = inc >= {1'b0, lim};
    assign stat.full1       = full1_reg;
    assign stat.div_done    = div_done;

endmodule

`default_nettype wire

### hdl/uer_ctrl.sv
`default_nettype none

// Controller: measurement phases per tick, then the arithmetic sequence.
module uer_ctrl
    import uer_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t stat,
    output dp_cmd_t         cmd
);

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_TRIG  = 11'b000_0000_0010,
        ST_WAIT  = 11'b000_0000_0100,
        ST_MEAS  = 11'b000_0000_1000,
        ST_MUL1  = 11'b000_0001_0000,
        ST_DIV1S = 11'b000_0010_0000,
        ST_DIV1W = 11'b000_0100_0000,
        ST_MUL2  = 11'b000_1000_0000,
        ST_DIV2S = 11'b001_0000_0000,
        ST_DIV2W = 11'b010_0000_0000,
        ST_FIN   = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   tick_state;
    logic   acc;

    // Ticks are taken only in the measurement phases and with buffer room.
    assign tick_state = (state_reg == ST_IDLE) || (state_reg == ST_TRIG) ||
                        (state_reg == ST_WAIT) || (state_reg == ST_MEAS);
    assign in_stall   = !tick_state || stat.full1;
    assign acc        = in_valid && !in_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.cnt_op = CNT_HOLD;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd.accept = 1'b1;
                    cmd.push   = 1'b1;
                    if (stat.start)
                    begin
                        cmd.res_trig = 1'b1;
                        cmd.res_busy = 1'b1;
                        if (stat.tlen_le1)
                        begin
                            cmd.cnt_op = CNT_CLR;
                            state_next = ST_WAIT;
                        end
                        else
                        begin
                            cmd.cnt_op = CNT_SET1;
                            state_next = ST_TRIG;
                        end
                    end
                end
            end
            ST_TRIG:
            begin
                if (acc)
                begin
                    cmd.accept   = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.res_trig = 1'b1;
                    cmd.res_busy = 1'b1;
                    if (stat.inc_ge_tlen)
                    begin
                        cmd.cnt_op = CNT_CLR;
                        state_next = ST_WAIT;
                    end
                    else
                    begin
                        cmd.cnt_op = CNT_INC;
                    end
                end
            end
            ST_WAIT:
            begin
                if (acc)
                begin
                    cmd.accept = 1'b1;
                    cmd.push   = 1'b1;
                    if (stat.echo_rise)
                    begin
                        cmd.cnt_op   = CNT_CLR;
                        cmd.res_busy = 1'b1;
                        state_next   = ST_MEAS;
                    end
                    else if (stat.inc_ge_lim)
                    begin
                        cmd.cnt_op   = CNT_CLR;
                        cmd.res_done = 1'b1;
                        cmd.res_err  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_op   = CNT_INC;
                        cmd.res_busy = 1'b1;
                    end
                end
            end
            ST_MEAS:
            begin
                if (acc)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.echo)
                    begin
                        // Falling edge: the counted width goes to the arithmetic.
                        cmd.cnt_op = CNT_INC;
                        state_next = ST_MUL1;
                    end
                    else if (stat.inc_ge_lim)
                    begin
                        cmd.cnt_op   = CNT_CLR;
                        cmd.push     = 1'b1;
                        cmd.res_done = 1'b1;
                        cmd.res_err  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_op   = CNT_INC;
                        cmd.push     = 1'b1;
                        cmd.res_busy = 1'b1;
                    end
                end
            end
            ST_MUL1:
            begin
                cmd.prod_cap = 1'b1;
                state_next   = ST_DIV1S;
            end
            ST_DIV1S:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV1W;
            end
            ST_DIV1W:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.prod_us = 1'b1;
                state_next  = ST_DIV2S;
            end
            ST_DIV2S:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_air = 1'b1;
                state_next      = ST_DIV2W;
            end
            ST_DIV2W:
            begin
                cmd.div_sel_air = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.push      = 1'b1;
                cmd.push_calc = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### dv/ultrasonic_echo_ranger_core_test.sv
`default_nettype none

module ultrasonic_echo_ranger_core_test
    import uer_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TICKS_PER_PHASE = 135;
    localparam int RANDOM_PHASES = 12;

    // Measurement phases of the ranger as the testbench tracks them.
    typedef enum logic [2:0] {
        RANGER_IDLE,
        RANGER_TRIG,
        RANGER_WAIT,
        RANGER_MEAS
    } ranger_phase_t;

    // Tracks the ranger state, predicts one reading per tick and checks the readings.
    class ranging_scoreboard;
        logic [15:0]   freq_khz;
        logic [15:0]   trig_len;
        logic [15:0]   timeout_len;
        logic [7:0]    air_temp;
        ranger_phase_t phase;
        int unsigned   count;
        bit            echo_last;
        out_item_t     due_readings[$];
        int            mismatches;

        function new();
            freq_khz = 16'd1000;
            trig_len = 16'd10;
            timeout_len = 16'hFFFF;
            air_temp = 8'd22;
            phase = RANGER_IDLE;
            count = 0;
            echo_last = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] val);
            case (idx)
                CFG_COUNTER_FREQ_KHZ: freq_khz = val;
                CFG_TRIGGER_TICKS:    trig_len = val;
                CFG_TIMEOUT_TICKS:    timeout_len = val;
                CFG_TEMPERATURE_C:    air_temp = val[7:0];
                default: ;
            endcase
        endfunction

        // Speed of sound in dm/s, less 15 for every full hundred.
        function int unsigned sound_speed();
            int unsigned a;
            a = 3313 + 6 * air_temp;
            a = a - (a / 100) * 15;
            return a;
        endfunction

        // Pulse width in microseconds from the captured tick count, saturated.
        function logic [15:0] pulse_us(int unsigned cap);
            longint unsigned us;
            if (freq_khz == 16'd0)
                return 16'hFFFF;
            us = (longint'(cap) * 1000) / freq_khz;
            return (us > 64'hFFFF) ? 16'hFFFF : us[15:0];
        endfunction

        task note_tick(in_item_t t);
            out_item_t   r;
            int unsigned tlen;
            int unsigned lim;
            r = '0;
            tlen = (trig_len == 16'd0) ? 1 : trig_len;
            lim = (timeout_len == 16'd0) ? 1 : timeout_len;
            case (phase)
                RANGER_IDLE:
                begin
                    if (t.start_req)
                    begin
                        r.trigger = 1'b1;
                        count = 1;
                        if (count >= tlen)
                        begin
                            phase = RANGER_WAIT;
                            count = 0;
                        end
                        else
                            phase = RANGER_TRIG;
                    end
                end
                RANGER_TRIG:
                begin
                    r.trigger = 1'b1;
                    count++;
                    if (count >= tlen)
                    begin
                        phase = RANGER_WAIT;
                        count = 0;
                    end
                end
                RANGER_WAIT:
                begin
                    if (t.echo && !echo_last)
                    begin
                        count = 0;
                        phase = RANGER_MEAS;
                    end
                    else
                    begin
                        count++;
                        if (count >= lim)
                        begin
                            r.done_res = 1'b1;
                            r.no_echo = 1'b1;
                            phase = RANGER_IDLE;
                            count = 0;
                        end
                    end
                end
                RANGER_MEAS:
                begin
                    count++;
                    if (!t.echo)
                    begin
                        r.done_res = 1'b1;
                        r.echo_us = pulse_us(count);
                        r.distance_cm = 16'(((r.echo_us * 100) / sound_speed()) / 2);
                        phase = RANGER_IDLE;
                    end
                    else if (count >= lim)
                    begin
                        r.done_res = 1'b1;
                        r.no_echo = 1'b1;
                        phase = RANGER_IDLE;
                        count = 0;
                    end
                end
                default: phase = RANGER_IDLE;
            endcase
            echo_last = t.echo;
            r.busy_res = (phase != RANGER_IDLE);
            due_readings.push_back(r);
        endtask

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_tick_result(out_item_t got);
            out_item_t want;
            if (due_readings.size() == 0)
            begin
                report_mismatch("reading with no tick waiting for it");
                return;
            end
            want = due_readings.pop_front();
            if (got.trigger !== want.trigger)
                report_mismatch($sformatf("trigger %b, want %b", got.trigger, want.trigger));
            if (got.busy_res !== want.busy_res)
                report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
            if (got.no_echo !== want.no_echo)
                report_mismatch($sformatf("no_echo %b, want %b", got.no_echo, want.no_echo));
            if (got.echo_us !== want.echo_us)
                report_mismatch($sformatf("echo_us %0d, want %0d", got.echo_us, want.echo_us));
            if (got.distance_cm !== want.distance_cm)
                report_mismatch($sformatf("distance_cm %0d, want %0d",
                                          got.distance_cm, want.distance_cm));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    ranging_scoreboard ranging = new();
    int  sent_ticks = 0;
    int  cycle_count = 0;
    bit  steady_in = 1'b1;
    bit  steady_out = 1'b1;

    ultrasonic_echo_ranger_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reading sink: unless steady_out is set, stalls a random number of cycles before taking each item.
    initial
    begin : reading_sink
        int hold;
        forever
        begin
            hold = steady_out ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            ranging.check_tick_result(out_data);
        end
    end

    // Sends one tick item, after a random gap unless steady_in is set, and records it once accepted.
    task automatic send_tick(input bit start, input bit echo_lvl);
        in_item_t t;
        int       gap;
        t.start_req = start;
        t.echo = echo_lvl;
        gap = steady_in ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= t;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        ranging.note_tick(t);
        sent_ticks++;
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        ranging.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic wait_readings_drained();
        @(posedge clk);
        while (ranging.due_readings.size() != 0) @(posedge clk);
    endtask

    // Brings a measurement in progress to its end with as few ticks as possible.
    task automatic finish_measurement();
        while (ranging.phase != RANGER_IDLE)
        begin
            if (ranging.phase == RANGER_WAIT && !ranging.echo_last)
                send_tick(1'b0, 1'b1);
            else
                send_tick(1'b0, 1'b0);
        end
        in_valid <= 1'b0;
    endtask

    // Picks a length that is short, medium, or within one of the count limit; only short above 64.
    function automatic int pick_len(int lim, int lo);
        int sel;
        sel = $urandom_range(0, 5);
        if (sel <= 1 || lim > 64)
            return $urandom_range(lo, 8);
        else if (sel <= 3)
            return $urandom_range(9, 80);
        else
            return lim - 1 + $urandom_range(0, 2);
    endfunction

    // One well-formed measurement: trigger, a quiet wait, an echo pulse, its fall.
    task automatic run_measurement();
        int tlen;
        int lim;
        int wait_len;
        int pulse_len;
        int i;
        tlen = (ranging.trig_len == 16'd0) ? 1 : ranging.trig_len;
        lim = (ranging.timeout_len == 16'd0) ? 1 : ranging.timeout_len;
        wait_len = pick_len(lim, 0);
        pulse_len = pick_len(lim, 1);
        for (i = 0; i < tlen; i++)
        begin
            if (i == tlen - 1)
                send_tick(i == 0 || $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
            else
                send_tick(i == 0 || $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
        end
        for (i = 0; i < wait_len; i++)
            send_tick($urandom_range(0, 7) == 0, 1'b0);
        for (i = 0; i < pulse_len; i++)
            send_tick($urandom_range(0, 7) == 0, 1'b1);
        send_tick($urandom_range(0, 7) == 0, 1'b0);
    endtask

    initial
    begin : stimulus
        int          ph;
        int          i;
        int          target;
        int          tail;
        logic [15:0] f;
        logic [15:0] tr;
        logic [15:0] to;
        logic [15:0] tc;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: idle ticks, then a measurement with restarts and echo
        // toggling during the trigger, which must both be ignored.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        for (i = 0; i < 9; i++)
            send_tick(1'b1, i[0]);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        finish_measurement();
        wait_readings_drained();

        // Zero trigger length, zero timeout, zero frequency, hottest air.
        write_reg(CFG_TRIGGER_TICKS, 16'd0);
        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        write_reg(CFG_COUNTER_FREQ_KHZ, 16'd0);
        write_reg(CFG_TEMPERATURE_C, 16'hFFFF);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        finish_measurement();
        wait_readings_drained();

        // Random phases, each under its own register settings.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    f = 16'd1;
                    tr = 16'd1;
                    to = 16'd1;
                    tc = 16'd0;
                end
                1:
                begin
                    f = 16'hFFFF;
                    tr = 16'd6;
                    to = 16'hFFFF;
                    tc = 16'h00FF;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: f = 16'd0;
                        1: f = 16'd1;
                        2: f = 16'hFFFF;
                        3: f = 16'd1000;
                        4: f = 16'($urandom_range(0, 65535));
                        default: f = 16'($urandom_range(1, 200));
                    endcase
                    case ($urandom_range(0, 4))
                        0: tr = 16'd0;
                        1: tr = 16'd1;
                        2: tr = 16'd2;
                        default: tr = 16'($urandom_range(3, 12));
                    endcase
                    case ($urandom_range(0, 5))
                        0: to = 16'd0;
                        1: to = 16'd1;
                        2: to = 16'hFFFF;
                        3: to = 16'($urandom_range(0, 65535));
                        default: to = 16'($urandom_range(2, 60));
                    endcase
                    tc = 16'($urandom_range(0, 65535));
                end
            endcase
            write_reg(CFG_COUNTER_FREQ_KHZ, f);
            write_reg(CFG_TRIGGER_TICKS, tr);
            write_reg(CFG_TIMEOUT_TICKS, to);
            write_reg(CFG_TEMPERATURE_C, tc);
            // An index past the register file must change nothing.
            if (ph == 5)
                write_reg(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));

            steady_in = (ph % 4 == 1);
            steady_out = (ph % 4 == 2);
            target = sent_ticks + TICKS_PER_PHASE;
            while (sent_ticks < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
                end
                else
                    run_measurement();
            end

            // Hold the sender until every reading is back before touching registers.
            finish_measurement();
            wait_readings_drained();
        end

        // Let the last readings arrive, with a bound of their own.
        tail = 0;
        while (ranging.due_readings.size() != 0 && tail < 5000)
        begin
            @(posedge clk);
            tail++;
        end
        if (ranging.due_readings.size() != 0)
            ranging.report_mismatch("readings still outstanding at the end");
        repeat (60) @(posedge clk);

        if (ranging.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
